FILE: src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared widths, types and register codes for the matrix-vector transform.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int LANES      = 4;
  localparam int COEF_W     = 16;
  localparam int DATA_W     = 32;
  localparam int ROW_W      = LANES * COEF_W;
  localparam int FRAC_SHIFT = 12;
  localparam int MAX_SIZE   = 4;
  localparam int SIZE_LIMIT = (MAX_SIZE < LANES) ? MAX_SIZE : LANES;
  localparam int SIZE_W     = 3;
  localparam int IDX_W      = 3;

  // Product, pair sum and full sum widths of one dot product.
  localparam int PROD_W = COEF_W + DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHR_W  = SUM_W - FRAC_SHIFT;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ROW0      = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW1      = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW2      = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW3      = 3'd3;
  localparam logic [IDX_W-1:0] REG_VEC_SIZE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TRANSPOSE = 3'd5;

  typedef logic [LANES-1:0][COEF_W-1:0] coef_row_t;
  typedef logic [LANES-1:0][DATA_W-1:0] vec_t;

  // Load enables of the stages inside each lane.
  typedef struct packed {
    logic prod_en;
    logic pair_en;
    logic sum_en;
    logic res_en;
  } mvt_ctl_t;

endpackage

FILE: src/matrix_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform
// Streams vectors through a 4x4 signed Q4.12 matrix, giving M*v or M^T*v.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   --------  -------------------  ----------------------------------------
//   in        in_valid / in_stall  in_x, in_y, in_z, in_w (Q16.16)
//   out       out_valid/out_stall  out_x..out_w (Q16.16), out_saturated
//   cfg       cfg_we               cfg_index, cfg_data (no read-back)
//
// One item can be accepted every cycle while in_stall is low. The edge
// that accepts an item loads the first of five register stages: input and
// coefficient capture, products, pair sums, rounded sum, saturation. The
// result is on the output once its item has passed through all of them, and
// it is taken at an edge where out_stall is low.
// Reset is synchronous and active low; it loads the identity matrix, a
// size of four and normal (non-transposed) mode, and empties the pipeline.
// A stage holds its item only while the stage after it is full and stalled,
// so empty stages keep filling while a finished result waits at the output.
// ----------------------------------------------------------------------------
module matrix_vector_transform #(
  parameter int MAX_SIZE = mvt_pkg::MAX_SIZE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_x,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_y,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_z,
  input  logic signed [mvt_pkg::DATA_W-1:0] in_w,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [mvt_pkg::IDX_W-1:0]         cfg_index,
  input  logic [mvt_pkg::ROW_W-1:0]         cfg_data
);
  import mvt_pkg::*;

  // Largest size in use: the smaller of the lane count and MAX_SIZE.
  localparam int SIZE_CAP = (MAX_SIZE < LANES) ? MAX_SIZE : LANES;

  // Configuration registers. Row r holds column c in bits [16c+15:16c].
  logic [ROW_W-1:0]  row_r [LANES];
  logic [SIZE_W-1:0] vec_size_r;
  logic              transpose_r;

  logic [SIZE_W-1:0] size_n;
  coef_row_t         coef_nxt [LANES];

  // Stage one holds the vector and the coefficient matrix already selected
  // for transpose mode and masked for the size in use.
  coef_row_t         coef1_r [LANES];
  vec_t              vec1_r;

  // One valid bit per stage: capture, products, pair sums, sum, result.
  logic [4:0]        valid_r;
  logic [4:0]        ready;
  mvt_ctl_t          ctl;

  logic signed [DATA_W-1:0] res [LANES];
  logic [LANES-1:0]         sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]    <= ROW_W'(64'h0000_0000_0000_1000);
      row_r[1]    <= ROW_W'(64'h0000_0000_1000_0000);
      row_r[2]    <= ROW_W'(64'h0000_1000_0000_0000);
      row_r[3]    <= ROW_W'(64'h1000_0000_0000_0000);
      vec_size_r  <= SIZE_W'(4);
      transpose_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0:      row_r[0]    <= cfg_data;
        REG_ROW1:      row_r[1]    <= cfg_data;
        REG_ROW2:      row_r[2]    <= cfg_data;
        REG_ROW3:      row_r[3]    <= cfg_data;
        REG_VEC_SIZE:  vec_size_r  <= cfg_data[SIZE_W-1:0];
        REG_TRANSPOSE: transpose_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sizes below two count as two; sizes past SIZE_CAP are clamped to it.
  always_comb begin
    size_n = vec_size_r;
    if (vec_size_r < SIZE_W'(2)) begin
      size_n = SIZE_W'(2);
    end else if (vec_size_r > SIZE_W'(SIZE_CAP)) begin
      size_n = SIZE_W'(SIZE_CAP);
    end
  end

  // Zeroing a coefficient outside the active square drops the unused input
  // components and makes unused result components exactly zero.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        if ((SIZE_W'(i) < size_n) && (SIZE_W'(j) < size_n)) begin
          coef_nxt[i][j] = transpose_r ? row_r[j][COEF_W*i +: COEF_W]
                                       : row_r[i][COEF_W*j +: COEF_W];
        end else begin
          coef_nxt[i][j] = '0;
        end
      end
    end
  end

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    ready[4] = !valid_r[4] || !out_stall;
    for (int k = 3; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  assign in_stall    = !ready[0];
  assign ctl.prod_en = ready[1];
  assign ctl.pair_en = ready[2];
  assign ctl.sum_en  = ready[3];
  assign ctl.res_en  = ready[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ready[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < 5; k++) begin
        if (ready[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      coef1_r   <= coef_nxt;
      vec1_r[0] <= in_x;
      vec1_r[1] <= in_y;
      vec1_r[2] <= in_z;
      vec1_r[3] <= in_w;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mvt_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coef   (coef1_r[g]),
      .vec    (vec1_r),
      .result (res[g]),
      .sat    (sat[g])
    );
  end

  assign out_valid     = valid_r[4];
  assign out_x         = res[0];
  assign out_y         = res[1];
  assign out_z         = res[2];
  assign out_w         = res[3];
  assign out_saturated = |sat;

`ifndef ASSERT_OFF
  // An accepted item always lands in the capture stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_r[0])
    else $error("accepted item did not enter the pipeline");

  // The input side only stalls when the capture stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> valid_r[0])
    else $error("input stalled with an empty capture stage");

  // A flagged result must carry at least one clamped component.
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_x == {1'b0, {(DATA_W-1){1'b1}}} || out_x == {1'b1, {(DATA_W-1){1'b0}}} ||
       out_y == {1'b0, {(DATA_W-1){1'b1}}} || out_y == {1'b1, {(DATA_W-1){1'b0}}} ||
       out_z == {1'b0, {(DATA_W-1){1'b1}}} || out_z == {1'b1, {(DATA_W-1){1'b0}}} ||
       out_w == {1'b0, {(DATA_W-1){1'b1}}} || out_w == {1'b1, {(DATA_W-1){1'b0}}}))
    else $error("saturation flag without a clamped component");

  // A stalled result leaves the output stage on the next edge only if taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_saturated)))
    else $error("stalled result changed");
`endif

endmodule

FILE: src/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane
// One result component: four products, pair sums, rounded sum, saturation.
// ----------------------------------------------------------------------------
module mvt_lane (
  input  logic               clk,
  input  mvt_pkg::mvt_ctl_t  ctl,
  input  mvt_pkg::coef_row_t coef,
  input  mvt_pkg::vec_t      vec,
  output logic signed [mvt_pkg::DATA_W-1:0] result,
  output logic               sat
);
  import mvt_pkg::*;

  logic signed [PROD_W-1:0] prod_r [LANES];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SHR_W-1:0]  shr;
  logic signed [DATA_W-1:0] res_nxt;
  logic                     sat_nxt;
  logic signed [DATA_W-1:0] res_r;
  logic                     sat_r;

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      for (int j = 0; j < LANES; j++) begin
        prod_r[j] <= $signed(coef[j]) * $signed(vec[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pair_en) begin
      pair_r[0] <= PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
      pair_r[1] <= PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
    end
  end

  // Round to nearest with ties toward plus infinity before the shift.
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum_r <= SUM_W'(pair_r[0]) + SUM_W'(pair_r[1])
             + SUM_W'(1 << (FRAC_SHIFT - 1));
    end
  end

  assign shr = sum_r[SUM_W-1:FRAC_SHIFT];

  always_comb begin
    res_nxt = shr[DATA_W-1:0];
    sat_nxt = 1'b0;
    if (shr[SHR_W-1:DATA_W-1] != {(SHR_W-DATA_W+1){shr[SHR_W-1]}}) begin
      sat_nxt = 1'b1;
      res_nxt = shr[SHR_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign result = res_r;
  assign sat    = sat_r;

endmodule
